FILE: hdl/i2tac_pkg.sv
// shared types, codes and defaults for the infix to three-address code block
`default_nettype none
package i2tac_pkg;

  // default stack depths
  localparam int OP_STACK_DEPTH_DEF    = 16;
  localparam int VALUE_STACK_DEPTH_DEF = 16;

  // token kinds
  localparam logic [2:0] REQ_OPERAND = 3'd0;
  localparam logic [2:0] REQ_OPEN    = 3'd1;
  localparam logic [2:0] REQ_CLOSE   = 3'd2;
  localparam logic [2:0] REQ_OPER    = 3'd3;
  localparam logic [2:0] REQ_END     = 3'd4;

  // instruction codes and the open paren mark on the operator stack
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_SUB     = 3'd1;
  localparam logic [2:0] OP_MUL     = 3'd2;
  localparam logic [2:0] OP_DIV     = 3'd3;
  localparam logic [2:0] OP_MOVE    = 3'd4;
  localparam logic [2:0] PAREN_MARK = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  // input request
  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  operator_code;
    logic [31:0] operand_value;
    logic [15:0] target_var;
  } in_req_t;

  // result request
  typedef struct packed {
    logic [2:0]  instr_op;
    logic        dest_is_target;
    logic [15:0] dest_index;
    logic        left_is_temp;
    logic [31:0] left_value;
    logic        right_is_temp;
    logic [31:0] right_value;
    logic [1:0]  error_code;
    logic        last;
  } out_req_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_DONE
  } state_t;

  // one step of work chosen by the controller
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH_VAL,
    ACT_PUSH_OP,
    ACT_OVF,
    ACT_POP_APPLY,
    ACT_POP_PAREN,
    ACT_DROP_PAREN,
    ACT_MOVE
  } act_t;

  // controller to datapath
  typedef struct packed {
    logic load_tok;
    logic push_val;
    logic push_op;
    logic pop_op;
    logic apply;
    logic gen_ovf;
    logic gen_move;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] tok_type;
    logic [1:0] tok_code;
    logic [2:0] op_top;
    logic       op_empty;
    logic       op_full;
    logic       val_full;
    logic       pend_valid;
    logic       out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: hdl/i2tac_ctrl.sv
// controller state machine: picks one stack step per pass and sequences results
`default_nettype none
module i2tac_ctrl
  import i2tac_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;
  act_t   act;
  logic   top_paren;
  logic   top_binds;
  logic   needs_gen;
  logic   stall;

  // decode the step for the current token and stack tops
  always_comb begin
    top_paren = (sts.op_top == PAREN_MARK);
    // pop while the stacked operator binds at least as tight as the new one
    top_binds = !sts.op_empty && !top_paren && !(sts.tok_code[1] && !sts.op_top[1]);
    act = ACT_NONE;
    case (sts.tok_type)
      REQ_OPERAND: act = sts.val_full ? ACT_OVF : ACT_PUSH_VAL;
      REQ_OPEN:    act = sts.op_full ? ACT_OVF : ACT_PUSH_OP;
      REQ_CLOSE: begin
        if (sts.op_empty) act = ACT_NONE;
        else if (top_paren) act = ACT_POP_PAREN;
        else act = ACT_POP_APPLY;
      end
      REQ_OPER: begin
        if (top_binds) act = ACT_POP_APPLY;
        else if (sts.op_full) act = ACT_OVF;
        else act = ACT_PUSH_OP;
      end
      REQ_END: begin
        if (sts.op_empty) act = ACT_MOVE;
        else if (top_paren) act = ACT_DROP_PAREN;
        else act = ACT_POP_APPLY;
      end
      default: act = ACT_NONE;
    endcase
    needs_gen = (act == ACT_OVF) || (act == ACT_POP_APPLY) || (act == ACT_MOVE);
    // a new result displaces the staged one, which needs a free output register
    stall = sts.pend_valid && !sts.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!(needs_gen && stall)) begin
          if (act == ACT_POP_APPLY || act == ACT_DROP_PAREN) state_nxt = ST_WAIT;
          else state_nxt = ST_DONE;
        end
      end
      ST_WAIT: state_nxt = ST_EXEC;
      ST_DONE: begin
        if (!stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_tok = in_valid;
      end
      ST_EXEC: begin
        if (!(needs_gen && stall)) begin
          case (act)
            ACT_PUSH_VAL:   cmd.push_val = 1'b1;
            ACT_PUSH_OP:    cmd.push_op  = 1'b1;
            ACT_OVF:        cmd.gen_ovf  = 1'b1;
            ACT_POP_APPLY: begin
              cmd.pop_op = 1'b1;
              cmd.apply  = 1'b1;
            end
            ACT_POP_PAREN:  cmd.pop_op   = 1'b1;
            ACT_DROP_PAREN: cmd.pop_op   = 1'b1;
            ACT_MOVE:       cmd.gen_move = 1'b1;
            default:        cmd          = '0;
          endcase
        end
      end
      ST_DONE: begin
        cmd.finish = !stall;
      end
      default: cmd = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/i2tac_dp.sv
// datapath: operator and operand stacks, temp counter, result staging and output
`default_nettype none
module i2tac_dp
  import i2tac_pkg::*;
#(
  parameter int OP_DEPTH  = OP_STACK_DEPTH_DEF,
  parameter int VAL_DEPTH = VALUE_STACK_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire in_req_t in_data,
  input  wire logic    out_ready,
  input  wire dp_cmd_t cmd,
  output dp_sts_t      sts,
  output logic         out_valid,
  output out_req_t     out_data
);

  localparam int OAW = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
  localparam int OCW = $clog2(OP_DEPTH + 1);
  localparam int VAW = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1;
  localparam int VCW = $clog2(VAL_DEPTH + 1);

  // stack memories, unreset
  logic [2:0]  op_mem  [OP_DEPTH];
  logic [32:0] val_mem [VAL_DEPTH];

  in_req_t     tok_r;
  logic [OCW-1:0] op_cnt_r, op_cnt_nxt;
  logic [VCW-1:0] val_cnt_r, val_cnt_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [2:0]  op_top_r;
  logic [32:0] val_top_r;
  logic [32:0] val_sec_r;
  out_req_t    pend_r, pend_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  out_req_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [OAW-1:0] op_top_addr;
  logic [OAW-1:0] op_wr_addr;
  logic [2:0]     op_wr_data;
  logic [VAW-1:0] val_top_addr;
  logic [VAW-1:0] val_sec_addr;
  logic [VAW-1:0] val_wr_addr;
  logic [32:0]    val_wr_data;
  logic           val_we;
  logic           val_lt2;
  logic           val_empty;
  logic           gen;
  logic           out_load;
  out_req_t       res;

  // stack addresses and flags
  always_comb begin
    op_top_addr  = OAW'(op_cnt_r - OCW'(1));
    op_wr_addr   = OAW'(op_cnt_r);
    op_wr_data   = (tok_r.req_type == REQ_OPEN) ? PAREN_MARK : {1'b0, tok_r.operator_code};
    val_top_addr = VAW'(val_cnt_r - VCW'(1));
    val_sec_addr = VAW'(val_cnt_r - VCW'(2));
    val_lt2      = (val_cnt_r < VCW'(2));
    val_empty    = (val_cnt_r == '0);
    val_we       = cmd.push_val || (cmd.apply && !val_lt2);
    val_wr_addr  = cmd.push_val ? VAW'(val_cnt_r) : val_sec_addr;
    val_wr_data  = cmd.push_val ? {1'b0, tok_r.operand_value} : {1'b1, 16'd0, temp_r};
  end

  // operator stack memory, registered read of the top
  always_ff @(posedge clk) begin
    if (cmd.push_op) op_mem[op_wr_addr] <= op_wr_data;
    op_top_r <= op_mem[op_top_addr];
  end

  // operand stack memory, registered reads of the top two
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wr_addr] <= val_wr_data;
    val_top_r <= val_mem[val_top_addr];
    val_sec_r <= val_mem[val_sec_addr];
  end

  // result built by the current step
  always_comb begin
    res = '0;
    if (cmd.gen_ovf) begin
      res.error_code = ERR_OVERFLOW;
    end else if (cmd.apply) begin
      res.instr_op = op_top_r;
      if (val_lt2) begin
        res.error_code = ERR_UNDERFLOW;
      end else begin
        res.dest_index    = temp_r;
        res.left_is_temp  = val_sec_r[32];
        res.left_value    = val_sec_r[31:0];
        res.right_is_temp = val_top_r[32];
        res.right_value   = val_top_r[31:0];
      end
    end else if (cmd.gen_move) begin
      res.instr_op       = OP_MOVE;
      res.dest_is_target = 1'b1;
      res.dest_index     = tok_r.target_var;
      if (val_empty) begin
        res.error_code = ERR_UNDERFLOW;
      end else begin
        res.left_is_temp = val_top_r[32];
        res.left_value   = val_top_r[31:0];
      end
    end
    gen = cmd.gen_ovf || cmd.apply || cmd.gen_move;
  end

  // counts and temp counter
  always_comb begin
    op_cnt_nxt  = op_cnt_r;
    val_cnt_nxt = val_cnt_r;
    temp_nxt    = temp_r;
    if (cmd.gen_move) begin
      op_cnt_nxt  = '0;
      val_cnt_nxt = '0;
    end else begin
      if (cmd.push_op) op_cnt_nxt = op_cnt_r + OCW'(1);
      else if (cmd.pop_op) op_cnt_nxt = op_cnt_r - OCW'(1);
      if (cmd.push_val) val_cnt_nxt = val_cnt_r + VCW'(1);
      else if (cmd.apply && !val_lt2) val_cnt_nxt = val_cnt_r - VCW'(1);
    end
    if (cmd.apply && !val_lt2) temp_nxt = temp_r + 16'd1;
  end

  // staged result moves out when a newer one arrives or the request finishes
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_load       = (gen || cmd.finish) && pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (out_load) begin
      out_nxt       = pend_r;
      out_nxt.last  = cmd.finish;
      out_valid_nxt = 1'b1;
    end
    if (gen) begin
      pend_nxt       = res;
      pend_valid_nxt = 1'b1;
    end else if (cmd.finish) begin
      pend_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_cnt_r     <= '0;
      val_cnt_r    <= '0;
      temp_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      op_cnt_r     <= op_cnt_nxt;
      val_cnt_r    <= val_cnt_nxt;
      temp_r       <= temp_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_tok) tok_r <= in_data;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // status to the controller
  always_comb begin
    sts.tok_type   = tok_r.req_type;
    sts.tok_code   = tok_r.operator_code;
    sts.op_top     = op_top_r;
    sts.op_empty   = (op_cnt_r == '0);
    sts.op_full    = (op_cnt_r == OCW'(OP_DEPTH));
    sts.val_full   = (val_cnt_r == VCW'(VAL_DEPTH));
    sts.pend_valid = pend_valid_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: hdl/infix_to_three_address_code.sv
// top level: infix token stream to three-address instructions
// Tokens of an infix expression enter on in_valid/in_ready with in_data; each
// request is one token. Instructions leave on out_valid/out_ready with
// out_data, and out_data.last marks the final instruction a token causes.
// Tokens are handled one at a time. A token that touches the stacks once
// (operand, open paren, push of an operator) is accepted in the idle state,
// updates the stacks in the exec state and releases the staged instruction
// in the done state; in_ready is high again once the block returns to idle.
// Each operator popped and applied, and each open paren dropped by an end
// token, adds a pass through the exec state, which updates the stacks, and
// the wait state, for the registered stack memory read of the new tops;
// the open paren matched by a close paren needs no wait state.
// An instruction is staged when built and moves to the output register when
// the next one is built or the token ends, which sets its last flag.
// A result may wait in the output register while the next token is accepted.
// If the receiver stalls, work stops at the next instruction that needs the
// output register; nothing is dropped. Reset (rst_n low, synchronous) empties
// both stacks, zeroes the temp counter and clears out_valid; stack memories
// are not cleared and need no clearing pass.
`default_nettype none
module infix_to_three_address_code
  import i2tac_pkg::*;
#(
  parameter int OP_STACK_DEPTH    = OP_STACK_DEPTH_DEF,
  parameter int VALUE_STACK_DEPTH = VALUE_STACK_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire in_req_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_req_t     out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller
  i2tac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  i2tac_dp #(
    .OP_DEPTH  (OP_STACK_DEPTH),
    .VAL_DEPTH (VALUE_STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // one token at a time: no acceptance right after an acceptance
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("token accepted while previous token in progress");

  // nothing stays staged once the block is ready for a token
  a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend_valid)
    else $error("staged instruction left behind");

  // a staged instruction never overwrites a stalled output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |->
      !(sts.pend_valid && (cmd.finish || cmd.apply || cmd.gen_ovf || cmd.gen_move)))
    else $error("output overwritten while stalled");
`endif

endmodule
`default_nettype wire
